// ===== rtl/uva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uva_pkg
// Shared operation codes, field widths and lane operand bundle for the
// three-lane unsigned vector ALU.
// ----------------------------------------------------------------------------
package uva_pkg;

    localparam int FIELD_W   = 32;  // width of every vector, scalar and result field
    localparam int OP_W      = 4;
    localparam int WIDTH_DEF = 32;  // default arithmetic width

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ADD   = 4'd0;  // a + b
    localparam op_t OP_SUB   = 4'd1;  // a - b
    localparam op_t OP_DOT   = 4'd2;  // dot(a, b) in lane x
    localparam op_t OP_CROSS = 4'd3;  // cross(a, b)
    localparam op_t OP_ADDS  = 4'd4;  // s + a
    localparam op_t OP_SVS   = 4'd5;  // s - a
    localparam op_t OP_VS    = 4'd6;  // a - s
    localparam op_t OP_MULS  = 4'd7;  // s * a
    localparam op_t OP_SDIV  = 4'd8;  // s / a, per lane
    localparam op_t OP_VDIV  = 4'd9;  // a / s, per lane

    // Operands one lane needs: its own a and b, the two cross-product
    // pairs (u0*u1 - u2*u3) and the scalar.
    typedef struct packed {
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] u0;
        logic [FIELD_W-1:0] u1;
        logic [FIELD_W-1:0] u2;
        logic [FIELD_W-1:0] u3;
        logic [FIELD_W-1:0] s;
    } lane_opnd_t;

endpackage

// ===== rtl/uva_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uva_lane
// One lane: multiply pair and add/sub in stage 0, cross difference in
// stage 1, and a one-bit-per-stage restoring divider over LW stages.
// ----------------------------------------------------------------------------
module uva_lane #(
    parameter int LW = uva_pkg::WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                en,        // whole pipeline advances
    input  uva_pkg::op_t        op_in,     // operation of the incoming request
    input  uva_pkg::lane_opnd_t opnd,
    input  uva_pkg::op_t        op_s0,     // operation held in stage 0
    output logic [LW-1:0]       arith_out, // add/sub/product/cross result
    output logic [LW-1:0]       quot_out   // quotient
);

    logic [LW-1:0] a_w, b_w, u0_w, u1_w, u2_w, u3_w, s_w;
    logic [LW-1:0] m0a, m0b, prod0, prod1;
    logic [LW-1:0] add_x, add_y, add_sum;
    logic          is_sub, is_mul;
    logic [LW-1:0] div_num, div_den;

    logic [LW-1:0] res_reg [0:LW];
    logic [LW-1:0] num_reg [0:LW];
    logic [LW-1:0] rem_reg [0:LW];
    logic [LW-1:0] den_reg [0:LW];
    logic [LW-1:0] p1_reg;

    always_comb begin
        a_w  = LW'(opnd.a);
        b_w  = LW'(opnd.b);
        u0_w = LW'(opnd.u0);
        u1_w = LW'(opnd.u1);
        u2_w = LW'(opnd.u2);
        u3_w = LW'(opnd.u3);
        s_w  = LW'(opnd.s);

        // multiplier 0 serves cross, dot and scalar multiply
        m0a = (op_in == uva_pkg::OP_CROSS) ? u0_w : a_w;
        if (op_in == uva_pkg::OP_CROSS) begin
            m0b = u1_w;
        end else if (op_in == uva_pkg::OP_DOT) begin
            m0b = b_w;
        end else begin
            m0b = s_w;
        end
        prod0 = m0a * m0b;
        prod1 = u2_w * u3_w;

        // one adder for all add/sub forms
        add_x = (op_in == uva_pkg::OP_SVS) ? s_w : a_w;
        if (op_in == uva_pkg::OP_ADD || op_in == uva_pkg::OP_SUB) begin
            add_y = b_w;
        end else if (op_in == uva_pkg::OP_SVS) begin
            add_y = a_w;
        end else begin
            add_y = s_w;
        end
        is_sub  = (op_in == uva_pkg::OP_SUB) || (op_in == uva_pkg::OP_SVS)
               || (op_in == uva_pkg::OP_VS);
        add_sum = is_sub ? (add_x - add_y) : (add_x + add_y);

        is_mul = (op_in == uva_pkg::OP_CROSS) || (op_in == uva_pkg::OP_DOT)
              || (op_in == uva_pkg::OP_MULS);

        div_num = (op_in == uva_pkg::OP_SDIV) ? s_w : a_w;
        div_den = (op_in == uva_pkg::OP_SDIV) ? a_w : s_w;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg[0] <= is_mul ? prod0 : add_sum;
            p1_reg     <= prod1;
            num_reg[0] <= div_num;
            rem_reg[0] <= '0;
            den_reg[0] <= div_den;
        end
    end

    // Restoring division, one quotient bit per stage. A zero divisor
    // yields all ones naturally.
    for (genvar j = 1; j <= LW; j++) begin : g_stage
        logic [LW:0]   shifted;
        logic [LW:0]   diff;
        logic          ge;
        logic [LW-1:0] res_next;

        always_comb begin
            shifted = {rem_reg[j-1], num_reg[j-1][LW-1]};
            diff    = shifted - {1'b0, den_reg[j-1]};
            ge      = (shifted >= {1'b0, den_reg[j-1]});
            if (j == 1 && op_s0 == uva_pkg::OP_CROSS) begin
                res_next = res_reg[j-1] - p1_reg;
            end else begin
                res_next = res_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[j] <= res_next;
                num_reg[j] <= {num_reg[j-1][LW-2:0], ge};
                rem_reg[j] <= ge ? diff[LW-1:0] : shifted[LW-1:0];
                den_reg[j] <= den_reg[j-1];
            end
        end
    end

    assign arith_out = res_reg[LW];
    assign quot_out  = num_reg[LW];

endmodule

// ===== rtl/uva_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uva_merge
// Combines the three lanes: dot product sum, quotient or lane result,
// zero for unused codes.
// ----------------------------------------------------------------------------
module uva_merge #(
    parameter int LW = uva_pkg::WIDTH_DEF
) (
    input  uva_pkg::op_t                  op,
    input  logic [LW-1:0]                 arith_x,
    input  logic [LW-1:0]                 arith_y,
    input  logic [LW-1:0]                 arith_z,
    input  logic [LW-1:0]                 quot_x,
    input  logic [LW-1:0]                 quot_y,
    input  logic [LW-1:0]                 quot_z,
    output logic [uva_pkg::FIELD_W-1:0]   r_x,
    output logic [uva_pkg::FIELD_W-1:0]   r_y,
    output logic [uva_pkg::FIELD_W-1:0]   r_z
);

    logic [LW-1:0] dot_sum;

    always_comb begin
        dot_sum = arith_x + arith_y + arith_z;
        case (op)
            uva_pkg::OP_ADD, uva_pkg::OP_SUB, uva_pkg::OP_CROSS,
            uva_pkg::OP_ADDS, uva_pkg::OP_SVS, uva_pkg::OP_VS,
            uva_pkg::OP_MULS: begin
                r_x = uva_pkg::FIELD_W'(arith_x);
                r_y = uva_pkg::FIELD_W'(arith_y);
                r_z = uva_pkg::FIELD_W'(arith_z);
            end
            uva_pkg::OP_DOT: begin
                r_x = uva_pkg::FIELD_W'(dot_sum);
                r_y = '0;
                r_z = '0;
            end
            uva_pkg::OP_SDIV, uva_pkg::OP_VDIV: begin
                r_x = uva_pkg::FIELD_W'(quot_x);
                r_y = uva_pkg::FIELD_W'(quot_y);
                r_z = uva_pkg::FIELD_W'(quot_z);
            end
            default: begin
                r_x = '0;
                r_y = '0;
                r_z = '0;
            end
        endcase
    end

endmodule

// ===== rtl/uint3_vector_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uint3_vector_alu
// Three-lane unsigned integer vector ALU with streaming in/out channels.
// ----------------------------------------------------------------------------
// One request in, one result out, in order. The block takes a new request
// every cycle while the pipeline is not stalled. A result is offered once
// its request has passed the per-lane divider, which resolves one quotient
// bit per stage over min(WIDTH,32) stages, and the one output register
// that follows it. Every operation runs down the same
// pipeline so results leave in request order. Arithmetic wraps modulo
// 2^WIDTH; WIDTH above 32 gives the same 32-bit results as 32. A zero
// divisor gives all ones in that lane (all lanes for a zero scalar).
// Unused operation codes return zero. No state is kept between requests;
// the pipeline only stalls when its last stage holds a result and the
// output register is full and not being taken.
// ----------------------------------------------------------------------------
module uint3_vector_alu #(
    parameter int WIDTH = uva_pkg::WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[3:0], a_x[35:4], a_y[67:36], a_z[99:68], b_x[131:100],
    // b_y[163:132], b_z[195:164], scalar_in[227:196], zero pad [231:228]
    input  logic [231:0] s_tdata,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_x[31:0], r_y[63:32], r_z[95:64]
    output logic [95:0]  m_tdata
);

    // lanes work at the narrower of WIDTH and the field width
    localparam int LW = (WIDTH < uva_pkg::FIELD_W) ? WIDTH : uva_pkg::FIELD_W;

    // request fields
    uva_pkg::op_t                 op_in;
    logic [uva_pkg::FIELD_W-1:0]  a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;

    // per-lane operand bundles
    uva_pkg::lane_opnd_t opnd_x, opnd_y, opnd_z;

    // pipeline control: stage 0 .. LW
    logic         v_reg  [0:LW];
    uva_pkg::op_t op_reg [0:LW];
    logic         en;

    logic [LW-1:0] arith_x, arith_y, arith_z;
    logic [LW-1:0] quot_x, quot_y, quot_z;
    logic [uva_pkg::FIELD_W-1:0] r_x, r_y, r_z;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    // ---- unpack request ----
    assign op_in     = s_tdata[3:0];
    assign a_x       = s_tdata[35:4];
    assign a_y       = s_tdata[67:36];
    assign a_z       = s_tdata[99:68];
    assign b_x       = s_tdata[131:100];
    assign b_y       = s_tdata[163:132];
    assign b_z       = s_tdata[195:164];
    assign scalar_in = s_tdata[227:196];

    // cross product routing: lane gets u0*u1 - u2*u3
    //   x: ay*bz - az*by   y: az*bx - ax*bz   z: ax*by - ay*bx
    assign opnd_x = '{a: a_x, b: b_x, u0: a_y, u1: b_z, u2: a_z, u3: b_y, s: scalar_in};
    assign opnd_y = '{a: a_y, b: b_y, u0: a_z, u1: b_x, u2: a_x, u3: b_z, s: scalar_in};
    assign opnd_z = '{a: a_z, b: b_z, u0: a_x, u1: b_y, u2: a_y, u3: b_x, s: scalar_in};

    // ---- flow control ----
    // Pipeline moves unless the last stage holds a result that cannot
    // drain into a full, stalled output register.
    assign en       = !(v_reg[LW] && m_tvalid_reg && !m_tready);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= LW; j++) begin
                v_reg[j] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int j = 1; j <= LW; j++) begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg[0] <= op_in;
            for (int j = 1; j <= LW; j++) begin
                op_reg[j] <= op_reg[j-1];
            end
        end
    end

    // ---- lanes ----
    uva_lane #(.LW(LW)) u_lane_x (
        .aclk      (aclk),
        .en        (en),
        .op_in     (op_in),
        .opnd      (opnd_x),
        .op_s0     (op_reg[0]),
        .arith_out (arith_x),
        .quot_out  (quot_x)
    );

    uva_lane #(.LW(LW)) u_lane_y (
        .aclk      (aclk),
        .en        (en),
        .op_in     (op_in),
        .opnd      (opnd_y),
        .op_s0     (op_reg[0]),
        .arith_out (arith_y),
        .quot_out  (quot_y)
    );

    uva_lane #(.LW(LW)) u_lane_z (
        .aclk      (aclk),
        .en        (en),
        .op_in     (op_in),
        .opnd      (opnd_z),
        .op_s0     (op_reg[0]),
        .arith_out (arith_z),
        .quot_out  (quot_z)
    );

    // ---- merge ----
    uva_merge #(.LW(LW)) u_merge (
        .op      (op_reg[LW]),
        .arith_x (arith_x),
        .arith_y (arith_y),
        .arith_z (arith_z),
        .quot_x  (quot_x),
        .quot_y  (quot_y),
        .quot_z  (quot_z),
        .r_x     (r_x),
        .r_y     (r_y),
        .r_z     (r_z)
    );

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && v_reg[LW]) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && v_reg[LW]) begin
            m_tdata_reg <= {r_z, r_y, r_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uint3_vector_alu. Requests are driven on the
// s_ stream channel and results are taken from the m_ channel. A lane
// predictor works out each expected result when its request is accepted.
// Results must arrive in order and match lane by lane. Both sides idle at
// random, one phase holds the output off long enough to back the pipeline
// up, and the sender drains the block fully between some phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF   = 10;    // 20 ns period
    localparam int RST_CYCLES = 7;
    localparam int IDLE_PCT   = 14;    // per-side idle chance, percent per cycle
    localparam int PIPE_LAT   = 33;    // request to result, WIDTH 32
    localparam int HOLD_LEN   = 300;   // long output hold-off, cycles
    localparam int TAIL_LIMIT = 4000;  // cycles allowed for the final drain

    // Codes the block leaves unused; they must return zero in every lane.
    localparam uva_pkg::op_t OP_UNUSED_LO = uva_pkg::OP_VDIV + 4'd1;
    localparam uva_pkg::op_t OP_UNUSED_HI = '1;

    typedef logic [uva_pkg::FIELD_W-1:0]      word_t;
    typedef logic [2:0][uva_pkg::FIELD_W-1:0] vec_t;   // [0] = x, [1] = y, [2] = z

    typedef struct packed {
        word_t        s;
        vec_t         b;
        vec_t         a;
        uva_pkg::op_t op;
    } alu_req_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // operation, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, zero pad (low to high)
    logic [231:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // r_x, r_y, r_z (low to high)
    logic [95:0]  m_tdata;

    vec_t lanes_due [$];   // expected result lanes, oldest first

    int  err_cnt      = 0;
    int  n_sent       = 0;
    int  n_checked    = 0;
    bit  tx_idle_en   = 1'b1;
    bit  rx_idle_en   = 1'b1;
    bit  hold_tog     = 1'b0;   // toggled by a test to ask for a hold-off
    bit  hold_seen    = 1'b0;
    int  hold_len     = 0;
    int  hold_left    = 0;

    uint3_vector_alu DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lane predictor: 32-bit context makes every sum, difference and
    // product wrap modulo 2^32 on its own.
    // ------------------------------------------------------------------
    function automatic vec_t alu_lanes(input alu_req_t r);
        vec_t res;
        res = '0;
        case (r.op)
            uva_pkg::OP_ADD:
                for (int i = 0; i < 3; i++) res[i] = r.a[i] + r.b[i];
            uva_pkg::OP_SUB:
                for (int i = 0; i < 3; i++) res[i] = r.a[i] - r.b[i];
            uva_pkg::OP_DOT:
                res[0] = r.a[0] * r.b[0] + r.a[1] * r.b[1] + r.a[2] * r.b[2];
            uva_pkg::OP_CROSS: begin
                res[0] = r.a[1] * r.b[2] - r.a[2] * r.b[1];
                res[1] = r.a[2] * r.b[0] - r.a[0] * r.b[2];
                res[2] = r.a[0] * r.b[1] - r.a[1] * r.b[0];
            end
            uva_pkg::OP_ADDS:
                for (int i = 0; i < 3; i++) res[i] = r.s + r.a[i];
            uva_pkg::OP_SVS:
                for (int i = 0; i < 3; i++) res[i] = r.s - r.a[i];
            uva_pkg::OP_VS:
                for (int i = 0; i < 3; i++) res[i] = r.a[i] - r.s;
            uva_pkg::OP_MULS:
                for (int i = 0; i < 3; i++) res[i] = r.s * r.a[i];
            // zero lane divisor saturates that lane only
            uva_pkg::OP_SDIV:
                for (int i = 0; i < 3; i++)
                    res[i] = (r.a[i] == '0) ? '1 : r.s / r.a[i];
            // zero scalar saturates all lanes
            uva_pkg::OP_VDIV:
                for (int i = 0; i < 3; i++)
                    res[i] = (r.s == '0) ? '1 : r.a[i] / r.s;
            default:  res = '0;
        endcase
        return res;
    endfunction

    // Operands lean toward the edges so zero divisors and wraps show up.
    function automatic word_t pick_operand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(7));
            3:       return ~word_t'($urandom_range(7));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic alu_req_t pick_request();
        alu_req_t r;
        if ($urandom_range(99) < 8)
            r.op = uva_pkg::op_t'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else
            r.op = uva_pkg::op_t'($urandom_range(uva_pkg::OP_VDIV, uva_pkg::OP_ADD));
        for (int i = 0; i < 3; i++) begin
            r.a[i] = pick_operand();
            r.b[i] = pick_operand();
        end
        r.s = pick_operand();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request, with an optional random gap in front. The
    // valid stays high on return so back-to-back requests need no gap.
    // ------------------------------------------------------------------
    task automatic send_request(input alu_req_t r);
        if (tx_idle_en) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lanes_due.push_back(alu_lanes(r));
        n_sent++;
    endtask

    task automatic send_operands(input uva_pkg::op_t op, input vec_t a, input vec_t b,
                                 input word_t s);
        alu_req_t r;
        r.op = op;
        r.a  = a;
        r.b  = b;
        r.s  = s;
        send_request(r);
    endtask

    // Sender stops and waits for every outstanding result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (lanes_due.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random idles, plus a counted hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        vec_t want;
        vec_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (lanes_due.size() == 0) begin
                $display("%0t: result with no request pending, actual %h", $time, got);
                err_cnt++;
            end else begin
                want = lanes_due.pop_front();
                n_checked++;
                for (int i = 0; i < 3; i++) begin
                    if (got[i] !== want[i]) begin
                        $display("%0t: lane %0d mismatch, expected %h, actual %h",
                                 $time, i, want[i], got[i]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation with all-ones operands, then add, sub, s-a and a-s with mostly zero operands.
    task automatic test_operation_extremes();
        for (int op = uva_pkg::OP_ADD; op <= uva_pkg::OP_VDIV; op++)
            send_operands(uva_pkg::op_t'(op), '1, '1, '1);
        send_operands(uva_pkg::OP_ADD, '0, '0, '0);
        send_operands(uva_pkg::OP_SUB, '0, {word_t'(1), word_t'(1), word_t'(1)}, '0);
        send_operands(uva_pkg::OP_SVS, '1, '0, '0);
        send_operands(uva_pkg::OP_VS, '0, '0, '1);
    endtask

    // Division by a zero lane and by a zero scalar.
    task automatic test_zero_divisors();
        send_operands(uva_pkg::OP_SDIV, {word_t'(0), word_t'(5), word_t'(0)}, '1, '1);
        send_operands(uva_pkg::OP_SDIV, '0, '0, word_t'(1234));
        send_operands(uva_pkg::OP_VDIV, '1, '0, '0);
        send_operands(uva_pkg::OP_VDIV, '0, '1, '0);
        send_operands(uva_pkg::OP_VDIV, {word_t'(7), word_t'(100), word_t'(3)}, '0,
                      word_t'(3));
    endtask

    // Codes past the last operation must give zero lanes.
    task automatic test_unused_codes();
        alu_req_t r;
        r = pick_request();
        send_operands(OP_UNUSED_LO, '1, '1, '1);
        send_operands(OP_UNUSED_HI, '1, '1, '1);
        send_operands(uva_pkg::op_t'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                      r.a, '1, '1);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(pick_request());
    endtask

    // Output held off while the sender keeps offering: the pipeline
    // fills up and has to stall the input.
    task automatic test_output_backpressure(input int count);
        tx_idle_en = 1'b0;
        hold_len   = HOLD_LEN;
        hold_tog   = ~hold_tog;
        repeat (count) send_request(pick_request());
        tx_idle_en = 1'b1;
    endtask

    // A stretch with no idling on either side.
    task automatic test_full_rate(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_request(pick_request());
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        int waited;
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_operation_extremes();
        test_zero_divisors();
        test_unused_codes();
        drain_results();

        test_random_traffic(450);
        drain_results();
        test_output_backpressure(150);
        test_full_rate(200);
        drain_results();
        test_random_traffic(230);

        s_tvalid <= 1'b0;
        waited = 0;
        while (lanes_due.size() != 0 && waited < TAIL_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (lanes_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, lanes_due.size());
            err_cnt++;
        end
        // catch anything extra the pipeline might still emit
        repeat (2 * PIPE_LAT) @(posedge aclk);

        $display("run covered %0d requests, %0d results checked", n_sent, n_checked);
        $display("all ten operations, unused codes, zero divisors, %0d-cycle output stall",
                 HOLD_LEN);
        if (err_cnt == 0) begin
            $display("[uint3_vector_alu] OK");
        end else begin
            $display("[uint3_vector_alu] ERROR");
        end
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("[uint3_vector_alu] ERROR");
        $finish;
    end

endmodule
